[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_CLK_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NORST(label, clk, prop)
`endif
`endif

[rtl/core/qfk_pkg.sv]
// Types, constants and helpers for the quaternion forward kinematics block.
package qfk_pkg;
   localparam int MaxJoints = 64;
   localparam int IdxW = 6;
   localparam int FracQ = 14;

   typedef struct packed {
      logic [5:0] joint_index;
      logic is_root;
      logic [5:0] parent_index;
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic signed [31:0] local_z;
      logic signed [15:0] local_qw;
      logic signed [15:0] local_qx;
      logic signed [15:0] local_qy;
      logic signed [15:0] local_qz;
   } req_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic signed [15:0] world_qw;
      logic signed [15:0] world_qx;
      logic signed [15:0] world_qy;
      logic signed [15:0] world_qz;
      logic bad_parent;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_QUAT, ST_MAT, ST_ROT, ST_DONE
   } state_type;

   // Operand pair for the shared multiplier; b holds a rotation matrix entry
   // (up to 20 bits after rounding) or a sign-extended Q1.14 value
   typedef struct packed {
      logic signed [31:0] a;
      logic signed [19:0] b;
   } mul_op_type;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      if (v > 36'sd32767) return 16'sh7fff;
      else if (v < -36'sd32768) return 16'sh8000;
      else return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage

[rtl/core/qfk_mul.sv]
// Shared signed 32x20 multiplier with registered product.
module qfk_mul (
   input  logic clock,
   input  qfk_pkg::mul_op_type op,
   output logic signed [51:0] prod_ff
);
   logic signed [51:0] prod_in;
   assign prod_in = op.a * op.b;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

[rtl/core/qfk_store.sv]
// Global transform store, one 160-bit row per joint, registered read.
module qfk_store (
   input  logic clock,
   input  logic wr_en,
   input  logic [qfk_pkg::IdxW-1:0] wr_addr,
   input  logic [159:0] wr_data,
   input  logic [qfk_pkg::IdxW-1:0] rd_addr,
   output logic [159:0] rd_data_ff
);
   logic [159:0] mem [qfk_pkg::MaxJoints];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

[rtl/core/quaternion_forward_kinematics_top.sv]
// Top level of quaternion forward kinematics: sequencer around one multiplier.
//  channel | dir | payload  | handshake
//  req     | in  | req_type | req_valid / req_stall
//  rsp     | out | rsp_type | rsp_valid / rsp_stall
// Root or bad-parent joints: result valid after the read and done states following acceptance.
// Child joints: result valid after the read, quaternion, matrix, position and done states;
// 16 + 10 + 9 products go through the one multiplier, each phase ending with a drain step.
// Next item is accepted no earlier than the cycle after the result has been taken.
// Synchronous active-high reset clears the sequencer and output valid; store is undefined.
// req_stall is high from acceptance until the result has been taken.
module quaternion_forward_kinematics_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  qfk_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output qfk_pkg::rsp_type rsp_data
);
   `include "assert_macros.svh"

   qfk_pkg::state_type state_ff, state_in;
   qfk_pkg::req_type item_ff, item_in;
   logic [5:0] step_ff, step_in;
   logic bad_ff, bad_in;
   logic signed [35:0] acc_ff, acc_in;
   logic signed [63:0] pacc_ff, pacc_in;
   logic signed [19:0] m_ff [9];
   logic signed [19:0] m_in [9];
   logic signed [35:0] sq_ff [10];
   logic signed [35:0] sq_in [10];
   logic signed [15:0] wq_ff [4];
   logic signed [15:0] wq_in [4];
   logic signed [31:0] wp_ff [3];
   logic signed [31:0] wp_in [3];
   qfk_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic wr_en;
   logic [159:0] rd_data;
   qfk_pkg::mul_op_type op;
   logic signed [51:0] prod;
   logic signed [15:0] pa [4];
   logic signed [15:0] lq [4];
   logic signed [31:0] lp [3];
   logic signed [31:0] pp [3];
   logic req_acc;

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != qfk_pkg::ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign pp[0] = rd_data[159:128];
   assign pp[1] = rd_data[127:96];
   assign pp[2] = rd_data[95:64];
   assign pa[0] = rd_data[63:48];
   assign pa[1] = rd_data[47:32];
   assign pa[2] = rd_data[31:16];
   assign pa[3] = rd_data[15:0];
   assign lq[0] = item_ff.local_qw;
   assign lq[1] = item_ff.local_qx;
   assign lq[2] = item_ff.local_qy;
   assign lq[3] = item_ff.local_qz;
   assign lp[0] = item_ff.local_x;
   assign lp[1] = item_ff.local_y;
   assign lp[2] = item_ff.local_z;

   qfk_store u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(item_ff.joint_index),
      .wr_data({rsp_in.world_x, rsp_in.world_y, rsp_in.world_z, rsp_in.world_qw,
                rsp_in.world_qx, rsp_in.world_qy, rsp_in.world_qz}),
      .rd_addr(item_ff.parent_index), .rd_data_ff(rd_data)
   );

   qfk_mul u_mul (.clock(clock), .op(op), .prod_ff(prod));

   // Quaternion product term tables: a index, b index, sign (1 = subtract)
   function automatic logic [4:0] qterm(input logic [3:0] k);
      unique case (k)
         4'd0: return {2'd0, 2'd0, 1'b0};
         4'd1: return {2'd1, 2'd1, 1'b1};
         4'd2: return {2'd2, 2'd2, 1'b1};
         4'd3: return {2'd3, 2'd3, 1'b1};
         4'd4: return {2'd1, 2'd0, 1'b0};
         4'd5: return {2'd0, 2'd1, 1'b0};
         4'd6: return {2'd2, 2'd3, 1'b0};
         4'd7: return {2'd3, 2'd2, 1'b1};
         4'd8: return {2'd2, 2'd0, 1'b0};
         4'd9: return {2'd0, 2'd2, 1'b0};
         4'd10: return {2'd3, 2'd1, 1'b0};
         4'd11: return {2'd1, 2'd3, 1'b1};
         4'd12: return {2'd3, 2'd0, 1'b0};
         4'd13: return {2'd0, 2'd3, 1'b0};
         4'd14: return {2'd1, 2'd2, 1'b0};
         default: return {2'd2, 2'd1, 1'b1};
      endcase
   endfunction

   // Products for matrix: ww xx yy zz xy xz yz wx wy wz
   function automatic logic [3:0] sqterm(input logic [3:0] k);
      unique case (k)
         4'd0: return {2'd0, 2'd0};
         4'd1: return {2'd1, 2'd1};
         4'd2: return {2'd2, 2'd2};
         4'd3: return {2'd3, 2'd3};
         4'd4: return {2'd1, 2'd2};
         4'd5: return {2'd1, 2'd3};
         4'd6: return {2'd2, 2'd3};
         4'd7: return {2'd0, 2'd1};
         4'd8: return {2'd0, 2'd2};
         default: return {2'd0, 2'd3};
      endcase
   endfunction

   // Column of the position product issued at step k (matrix is row-major)
   function automatic logic [1:0] rot_col(input logic [3:0] k);
      unique case (k)
         4'd0, 4'd3, 4'd6: return 2'd0;
         4'd1, 4'd4, 4'd7: return 2'd1;
         default: return 2'd2;
      endcase
   endfunction

   // Output row completed at step k (3, 6 or 9)
   function automatic logic [1:0] rot_row(input logic [5:0] k);
      unique case (k)
         6'd3: return 2'd0;
         6'd6: return 2'd1;
         default: return 2'd2;
      endcase
   endfunction

   // Matrix entries are rounded without saturation and need 20 bits
   function automatic logic signed [19:0] rnd14(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = (v + 36'sd8192) >>> qfk_pkg::FracQ;
      return t[19:0];
   endfunction

   // Operand select
   always_comb begin
      logic [4:0] qt;
      logic [3:0] st;
      logic [3:0] ri;
      qt = qterm(step_ff[3:0]);
      st = sqterm(step_ff[3:0]);
      ri = 4'(step_ff);
      op = '0;
      unique case (state_ff)
         qfk_pkg::ST_QUAT: begin
            op.a = 32'(pa[qt[4:3]]);
            op.b = 20'(lq[qt[2:1]]);
         end
         qfk_pkg::ST_MAT: begin
            op.a = 32'(pa[st[3:2]]);
            op.b = 20'(pa[st[1:0]]);
         end
         qfk_pkg::ST_ROT: begin
            op.a = lp[rot_col(ri)];
            op.b = (ri < 4'd9) ? m_ff[ri] : '0;
         end
         default: op = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qfk_pkg::ST_IDLE: if (req_acc) state_in = qfk_pkg::ST_READ;
         qfk_pkg::ST_READ:
            state_in = bad_ff || item_ff.is_root ? qfk_pkg::ST_DONE : qfk_pkg::ST_QUAT;
         qfk_pkg::ST_QUAT: if (step_ff == 6'd16) state_in = qfk_pkg::ST_MAT;
         qfk_pkg::ST_MAT: if (step_ff == 6'd10) state_in = qfk_pkg::ST_ROT;
         qfk_pkg::ST_ROT: if (step_ff == 6'd9) state_in = qfk_pkg::ST_DONE;
         qfk_pkg::ST_DONE: state_in = qfk_pkg::ST_IDLE;
         default: state_in = qfk_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      logic signed [35:0] pterm;
      logic signed [35:0] s;
      logic [4:0] qtp;
      logic signed [63:0] pt;
      logic signed [63:0] racc;
      logic [1:0] row;
      item_in = item_ff;
      step_in = step_ff;
      bad_in = bad_ff;
      acc_in = acc_ff;
      pacc_in = pacc_ff;
      m_in = m_ff;
      sq_in = sq_ff;
      wq_in = wq_ff;
      wp_in = wp_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      pterm = prod[35:0];
      qtp = qterm(4'(step_ff - 6'd1));
      pt = 64'(prod);
      s = '0;
      racc = '0;
      row = rot_row(step_ff);
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         qfk_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_acc) begin
               item_in = req_data;
               bad_in = !req_data.is_root && (req_data.parent_index >= req_data.joint_index);
            end
         end
         qfk_pkg::ST_READ: begin
            step_in = '0;
            acc_in = '0;
         end
         qfk_pkg::ST_QUAT: begin
            step_in = step_ff + 6'd1;
            if (step_ff != 6'd0) begin
               s = qtp[0] ? acc_ff - pterm : acc_ff + pterm;
               if (step_ff[1:0] == 2'd0) begin
                  wq_in[2'(step_ff[5:2] - 4'd1)] =
                     qfk_pkg::sat16((s + 36'sd8192) >>> qfk_pkg::FracQ);
                  acc_in = '0;
               end else begin
                  acc_in = s;
               end
            end
            if (step_ff == 6'd16) step_in = '0;
         end
         qfk_pkg::ST_MAT: begin
            step_in = step_ff + 6'd1;
            if (step_ff != 6'd0) sq_in[4'(step_ff - 6'd1)] = pterm;
            if (step_ff == 6'd10) begin
               step_in = '0;
               m_in[0] = rnd14(sq_in[1] + sq_in[0] - sq_in[2] - sq_in[3]);
               m_in[1] = rnd14((sq_in[4] - sq_in[9]) <<< 1);
               m_in[2] = rnd14((sq_in[5] + sq_in[8]) <<< 1);
               m_in[3] = rnd14((sq_in[9] + sq_in[4]) <<< 1);
               m_in[4] = rnd14(sq_in[0] - sq_in[1] + sq_in[2] - sq_in[3]);
               m_in[5] = rnd14((sq_in[6] - sq_in[7]) <<< 1);
               m_in[6] = rnd14((sq_in[5] - sq_in[8]) <<< 1);
               m_in[7] = rnd14((sq_in[7] + sq_in[6]) <<< 1);
               m_in[8] = rnd14(sq_in[0] - sq_in[1] - sq_in[2] + sq_in[3]);
               pacc_in = '0;
            end
         end
         qfk_pkg::ST_ROT: begin
            step_in = step_ff + 6'd1;
            if (step_ff != 6'd0) begin
               racc = pacc_ff + pt;
               if ((step_ff == 6'd3) || (step_ff == 6'd6) || (step_ff == 6'd9)) begin
                  wp_in[row] = qfk_pkg::sat32(
                     ((racc + 64'sd8192) >>> qfk_pkg::FracQ) + 64'(pp[row]));
                  pacc_in = '0;
               end else begin
                  pacc_in = racc;
               end
            end
         end
         qfk_pkg::ST_DONE: begin
            if (bad_ff || item_ff.is_root) begin
               rsp_in.world_x = item_ff.local_x;
               rsp_in.world_y = item_ff.local_y;
               rsp_in.world_z = item_ff.local_z;
               rsp_in.world_qw = item_ff.local_qw;
               rsp_in.world_qx = item_ff.local_qx;
               rsp_in.world_qy = item_ff.local_qy;
               rsp_in.world_qz = item_ff.local_qz;
            end else begin
               rsp_in.world_x = wp_ff[0];
               rsp_in.world_y = wp_ff[1];
               rsp_in.world_z = wp_ff[2];
               rsp_in.world_qw = wq_ff[0];
               rsp_in.world_qx = wq_ff[1];
               rsp_in.world_qy = wq_ff[2];
               rsp_in.world_qz = wq_ff[3];
            end
            rsp_in.bad_parent = bad_ff;
            rsp_valid_in = 1'b1;
            wr_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qfk_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff <= step_in;
      end
      item_ff <= item_in;
      bad_ff <= bad_in;
      acc_ff <= acc_in;
      pacc_ff <= pacc_in;
      m_ff <= m_in;
      sq_ff <= sq_in;
      wq_ff <= wq_in;
      wp_ff <= wp_in;
      rsp_ff <= rsp_in;
   end

   `ASSERT_CLK(a_no_accept_busy, clock, reset, (state_ff != qfk_pkg::ST_IDLE) |-> !req_acc)
   `ASSERT_CLK(a_done_valid, clock, reset, (state_ff == qfk_pkg::ST_DONE) |=> rsp_valid)
   `ASSERT_CLK(a_bad_not_root, clock, reset, (rsp_valid && rsp_data.bad_parent) |-> !item_ff.is_root)
endmodule
